[rtl/skt_pkg.sv]
// Shared types and codes for the sorted key table block.
package skt_pkg;

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_RANGE  = 2'd2,
      FUNC_OPEN   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_FULL = 2'd1,
      ST_NONE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_SCAN,
      ENG_WRITE,
      ENG_FINISH
   } state_type;

   localparam int unsigned KEY_W   = 32;
   localparam int unsigned TAG_W   = 16;
   localparam int unsigned COUNT_W = 6;

   typedef struct packed {
      func_type           func;
      logic [KEY_W-1:0]   item_key;
      logic [TAG_W-1:0]   item_tag;
      logic [KEY_W-1:0]   from_key;
      logic [KEY_W-1:0]   to_key;
   } req_item_type;

   typedef struct packed {
      logic [TAG_W-1:0]   entry_tag;
      logic [KEY_W-1:0]   entry_key;
      logic               has_entry;
      logic [COUNT_W-1:0] match_count;
      logic               last;
      status_type         status;
   } rsp_item_type;

endpackage

[rtl/skt_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module skt_ram #(
   parameter int unsigned WIDTH = 48,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/skt_engine.sv]
// Table sequencer: scans, shifts and compacts the entry RAM and builds results.
module skt_engine #(
   parameter int unsigned DEPTH    = 32,
   parameter int unsigned KEY_BITS = 32,
   parameter int unsigned TAG_BITS = 16,
   parameter int unsigned AW       = 5,
   parameter int unsigned CNW      = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  skt_pkg::req_item_type         req_item,
   input  logic                          out_free,
   output logic                          push_valid,
   output skt_pkg::rsp_item_type         push_item,
   output logic                          ram_we,
   output logic [AW-1:0]                 ram_waddr,
   output logic [TAG_BITS+KEY_BITS-1:0]  ram_wdata,
   output logic                          ram_re,
   output logic [AW-1:0]                 ram_raddr,
   input  logic [TAG_BITS+KEY_BITS-1:0]  ram_rdata
);

   localparam int unsigned CMPW = (KEY_BITS > skt_pkg::KEY_W) ? KEY_BITS : skt_pkg::KEY_W;

   skt_pkg::state_type state_ff, state_in;
   skt_pkg::func_type  op_ff, op_in;
   logic [CNW-1:0]      cnt_ff, cnt_in;
   logic [CNW-1:0]      rem_ff, rem_in;
   logic [CNW-1:0]      wr_ff, wr_in;
   logic [CNW-1:0]      mcnt_ff, mcnt_in;
   logic [AW-1:0]       ptr_ff, ptr_in;
   logic [AW-1:0]       ev_ptr_ff, ev_ptr_in;
   logic [AW-1:0]       pos_ff, pos_in;
   logic                rd_vld_ff, rd_vld_in;
   logic                pend_vld_ff, pend_vld_in;
   logic                full_ff, full_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic [skt_pkg::KEY_W-1:0] from_ff, from_in;
   logic [skt_pkg::KEY_W-1:0] to_ff, to_in;
   logic [KEY_BITS-1:0] pend_key_ff, pend_key_in;
   logic [TAG_BITS-1:0] pend_tag_ff, pend_tag_in;

   logic [KEY_BITS-1:0] rd_key;
   logic [TAG_BITS-1:0] rd_tag;
   logic                ins_shift;
   logic                rem_keep;
   logic                q_low;
   logic                q_high;
   logic                q_match;
   logic                is_query;
   logic                stall;
   logic                stop;
   logic                issue;
   logic                scan_end;
   logic [CNW-1:0]      removed;

   assign rd_key   = ram_rdata[KEY_BITS-1:0];
   assign rd_tag   = ram_rdata[KEY_BITS +: TAG_BITS];
   assign is_query = (op_ff == skt_pkg::FUNC_RANGE) || (op_ff == skt_pkg::FUNC_OPEN);
   assign ins_shift = rd_key >= key_ff;
   assign rem_keep  = rd_tag != tag_ff;
   assign q_low     = CMPW'(rd_key) < CMPW'(from_ff);
   assign q_high    = (op_ff == skt_pkg::FUNC_RANGE) && (CMPW'(rd_key) >= CMPW'(to_ff));
   assign q_match   = !q_low && !q_high;
   assign removed   = cnt_ff - wr_ff;

   // A query match pushes the previously held entry, so it waits on a full output.
   assign stall = rd_vld_ff && is_query && q_match && pend_vld_ff && !out_free;
   assign stop  = rd_vld_ff && (((op_ff == skt_pkg::FUNC_INSERT) && !ins_shift) ||
                                (is_query && !q_low && q_high));
   assign issue    = (state_ff == skt_pkg::ENG_SCAN) && !stall && !stop && (rem_ff != '0);
   assign scan_end = stop || (!rd_vld_ff && (rem_ff == '0));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         skt_pkg::ENG_IDLE: begin
            if (req_valid) begin
               if ((req_item.func == skt_pkg::FUNC_INSERT) && (cnt_ff == CNW'(DEPTH))) begin
                  state_in = skt_pkg::ENG_FINISH;
               end else begin
                  state_in = skt_pkg::ENG_SCAN;
               end
            end
         end
         skt_pkg::ENG_SCAN: begin
            if (scan_end) begin
               state_in = (op_ff == skt_pkg::FUNC_INSERT) ? skt_pkg::ENG_WRITE
                                                           : skt_pkg::ENG_FINISH;
            end
         end
         skt_pkg::ENG_WRITE: begin
            state_in = skt_pkg::ENG_FINISH;
         end
         skt_pkg::ENG_FINISH: begin
            if (out_free) begin
               state_in = skt_pkg::ENG_IDLE;
            end
         end
         default: begin
            state_in = skt_pkg::ENG_IDLE;
         end
      endcase
   end

   always_comb begin
      op_in       = op_ff;
      cnt_in      = cnt_ff;
      rem_in      = rem_ff;
      wr_in       = wr_ff;
      mcnt_in     = mcnt_ff;
      ptr_in      = ptr_ff;
      ev_ptr_in   = ev_ptr_ff;
      pos_in      = pos_ff;
      rd_vld_in   = rd_vld_ff;
      pend_vld_in = pend_vld_ff;
      full_in     = full_ff;
      key_in      = key_ff;
      tag_in      = tag_ff;
      from_in     = from_ff;
      to_in       = to_ff;
      pend_key_in = pend_key_ff;
      pend_tag_in = pend_tag_ff;
      req_ready   = 1'b0;
      push_valid  = 1'b0;
      push_item   = '0;
      ram_we      = 1'b0;
      ram_waddr   = '0;
      ram_wdata   = '0;
      ram_re      = 1'b0;
      ram_raddr   = ptr_ff;

      unique case (state_ff)
         skt_pkg::ENG_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in       = req_item.func;
               key_in      = KEY_BITS'(req_item.item_key);
               tag_in      = TAG_BITS'(req_item.item_tag);
               from_in     = req_item.from_key;
               to_in       = req_item.to_key;
               full_in     = (req_item.func == skt_pkg::FUNC_INSERT) &&
                             (cnt_ff == CNW'(DEPTH));
               rem_in      = cnt_ff;
               ptr_in      = (req_item.func == skt_pkg::FUNC_INSERT) ?
                             AW'(cnt_ff - CNW'(1)) : '0;
               rd_vld_in   = 1'b0;
               pos_in      = '0;
               wr_in       = '0;
               mcnt_in     = '0;
               pend_vld_in = 1'b0;
            end
         end
         skt_pkg::ENG_SCAN: begin
            if (rd_vld_ff && !stall) begin
               unique case (op_ff) inside
                  skt_pkg::FUNC_INSERT: begin
                     // Insert walks down from the top, moving each key not smaller than the new key up one slot.
                     if (ins_shift) begin
                        ram_we    = 1'b1;
                        ram_waddr = ev_ptr_ff + AW'(1);
                        ram_wdata = ram_rdata;
                     end else begin
                        pos_in = ev_ptr_ff + AW'(1);
                     end
                  end
                  skt_pkg::FUNC_REMOVE: begin
                     if (rem_keep) begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(wr_ff);
                        ram_wdata = ram_rdata;
                        wr_in     = wr_ff + CNW'(1);
                     end
                  end
                  skt_pkg::FUNC_RANGE, skt_pkg::FUNC_OPEN: begin
                     if (q_match) begin
                        if (pend_vld_ff) begin
                           push_valid            = 1'b1;
                           push_item.entry_tag   = skt_pkg::TAG_W'(pend_tag_ff);
                           push_item.entry_key   = skt_pkg::KEY_W'(pend_key_ff);
                           push_item.has_entry   = 1'b1;
                           push_item.status      = skt_pkg::ST_DONE;
                        end
                        pend_vld_in = 1'b1;
                        pend_key_in = rd_key;
                        pend_tag_in = rd_tag;
                        mcnt_in     = mcnt_ff + CNW'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
            if (issue) begin
               ram_re    = 1'b1;
               ram_raddr = ptr_ff;
               ev_ptr_in = ptr_ff;
               ptr_in    = (op_ff == skt_pkg::FUNC_INSERT) ? ptr_ff - AW'(1)
                                                          : ptr_ff + AW'(1);
               rem_in    = rem_ff - CNW'(1);
               rd_vld_in = 1'b1;
            end else if (!stall) begin
               rd_vld_in = 1'b0;
            end
         end
         skt_pkg::ENG_WRITE: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff;
            ram_wdata = {tag_ff, key_ff};
            cnt_in    = cnt_ff + CNW'(1);
         end
         skt_pkg::ENG_FINISH: begin
            if (out_free) begin
               push_valid     = 1'b1;
               push_item.last = 1'b1;
               unique case (op_ff) inside
                  skt_pkg::FUNC_INSERT: begin
                     if (full_ff) begin
                        push_item.status = skt_pkg::ST_FULL;
                     end else begin
                        push_item.entry_tag   = skt_pkg::TAG_W'(tag_ff);
                        push_item.entry_key   = skt_pkg::KEY_W'(key_ff);
                        push_item.has_entry   = 1'b1;
                        push_item.match_count = skt_pkg::COUNT_W'(1);
                        push_item.status      = skt_pkg::ST_DONE;
                     end
                  end
                  skt_pkg::FUNC_REMOVE: begin
                     cnt_in                = wr_ff;
                     push_item.match_count = skt_pkg::COUNT_W'(removed);
                     push_item.status      = (removed != '0) ? skt_pkg::ST_DONE
                                                             : skt_pkg::ST_NONE;
                  end
                  skt_pkg::FUNC_RANGE, skt_pkg::FUNC_OPEN: begin
                     if (pend_vld_ff) begin
                        push_item.entry_tag   = skt_pkg::TAG_W'(pend_tag_ff);
                        push_item.entry_key   = skt_pkg::KEY_W'(pend_key_ff);
                        push_item.has_entry   = 1'b1;
                        push_item.match_count = skt_pkg::COUNT_W'(mcnt_ff);
                        push_item.status      = skt_pkg::ST_DONE;
                     end else begin
                        push_item.status = skt_pkg::ST_NONE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= skt_pkg::ENG_IDLE;
         cnt_ff      <= '0;
         rd_vld_ff   <= 1'b0;
         pend_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         rd_vld_ff   <= rd_vld_in;
         pend_vld_ff <= pend_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      rem_ff      <= rem_in;
      wr_ff       <= wr_in;
      mcnt_ff     <= mcnt_in;
      ptr_ff      <= ptr_in;
      ev_ptr_ff   <= ev_ptr_in;
      pos_ff      <= pos_in;
      full_ff     <= full_in;
      key_ff      <= key_in;
      tag_ff      <= tag_in;
      from_ff     <= from_in;
      to_ff       <= to_in;
      pend_key_ff <= pend_key_in;
      pend_tag_ff <= pend_tag_in;
   end

   // The scan never reads an entry in the cycle it is being rewritten.
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
      else $error("RAM read and write hit the same entry");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNW'(DEPTH))
      else $error("entry count exceeds table depth");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> out_free)
      else $error("result pushed into a full output register");

   a_read_from_scan: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> $past(state_ff == skt_pkg::ENG_SCAN))
      else $error("read data pending outside a scan");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == skt_pkg::ENG_IDLE) |-> !ram_we)
      else $error("table written while idle");

endmodule

[rtl/sorted_key_table_range_query.sv]
// Sorted key table top level: stream ports, entry RAM, sequencer and result register.
// A transaction steps through acceptance, a scan of pipelined RAM reads over the entries, use
// of the last read and the close of the scan, a write for an insert, and the load of the final
// result; an insert into a full table goes from acceptance straight to the final result.
// The single RAM port pair paces the scan; query results stream out during the scan.
// Reset empties the table by clearing the entry count; no clearing pass.
module sorted_key_table_range_query #(
   parameter int unsigned DEPTH    = 32,
   parameter int unsigned KEY_BITS = 32,
   parameter int unsigned TAG_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [111:0] req_tdata,  // item_key[31:0], item_tag[47:32], from_key[79:48], to_key[111:80]
   input  logic [1:0]   req_tuser,  // func[1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [55:0]  rsp_tdata,  // entry_tag[15:0], entry_key[47:16], match_count[53:48], zero pad
   output logic [2:0]   rsp_tuser,  // has_entry[0], status[2:1]
   output logic         rsp_tlast   // last
);

   localparam int unsigned AW  = $clog2(DEPTH);
   localparam int unsigned CNW = $clog2(DEPTH + 1);
   localparam int unsigned EW  = TAG_BITS + KEY_BITS;

   skt_pkg::req_item_type req_item;
   skt_pkg::rsp_item_type push_item;
   skt_pkg::rsp_item_type rsp_item_ff, rsp_item_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   logic                  push_valid;
   logic                  out_free;
   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   logic [EW-1:0]         ram_wdata;
   logic                  ram_re;
   logic [AW-1:0]         ram_raddr;
   logic [EW-1:0]         ram_rdata;

   always_comb begin
      req_item.func     = skt_pkg::func_type'(req_tuser);
      req_item.item_key = req_tdata[31:0];
      req_item.item_tag = req_tdata[47:32];
      req_item.from_key = req_tdata[79:48];
      req_item.to_key   = req_tdata[111:80];
   end

   skt_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   skt_engine #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS),
      .TAG_BITS (TAG_BITS),
      .AW       (AW),
      .CNW      (CNW)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_item   (req_item),
      .out_free   (out_free),
      .push_valid (push_valid),
      .push_item  (push_item),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_re     (ram_re),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata)
   );

   // The result register takes a new result whenever the current one is empty or leaving.
   assign out_free = !rsp_vld_ff || rsp_tready;

   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_item_in = rsp_item_ff;
      if (push_valid) begin
         rsp_vld_in  = 1'b1;
         rsp_item_in = push_item;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {2'b00, rsp_item_ff.match_count, rsp_item_ff.entry_key,
                        rsp_item_ff.entry_tag};
   assign rsp_tuser  = {rsp_item_ff.status, rsp_item_ff.has_entry};
   assign rsp_tlast  = rsp_item_ff.last;

endmodule
